[rtl/normalized_kernel_convolution_unit_assert.svh]
// Assertion macros for the normalized kernel convolution unit.
// Included by the top level; needs no other file.
`ifndef NORMALIZED_KERNEL_CONVOLUTION_UNIT_ASSERT_SVH
`define NORMALIZED_KERNEL_CONVOLUTION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define NKC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("nkc assertion failed");
`define NKC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("nkc assertion failed");
`else
`define NKC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define NKC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

[rtl/nkc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and kernel weights of the convolution unit.
// No dependencies.
package nkc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 2;

  localparam int CFG_W     = 11;
  localparam int SZW       = 13;
  localparam int REG_IDX_W = 2;
  localparam int ACCW      = 17;
  localparam int NRMW      = 7;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_SELECT = 2'd2;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       pad;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_RS_POS, ST_RS_POS_W, ST_RS_RING, ST_RS_RING_W,
    ST_MUL, ST_CHECK, ST_TAP, ST_DRAIN, ST_DIV, ST_DIV_W, ST_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    DIV_POS, DIV_RING, DIV_RED, DIV_GREEN, DIV_BLUE
  } div_src_t;

  typedef struct packed {
    logic     capture;
    logic     write_step;
    logic     mul;
    logic     restart;
    logic     tap_init;
    logic     tap_step;
    logic     div_start;
    logic     div_latch;
    div_src_t div_src;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic resync;
    logic div_done;
    logic past_end;
    logic not_ready;
    logic tap_last;
    logic out_free;
  } dp_stat_t;

  // Blur: center 20, inner ring 3, outer ring 1. Sharpen: center 27, others -1.
  function automatic logic signed [5:0] tap_weight(logic sel, logic [2:0] ky,
                                                   logic [2:0] kx);
    logic [2:0] dy;
    logic [2:0] dx;
    logic [2:0] d;
    dy = (ky >= 3'd2) ? ky - 3'd2 : 3'd2 - ky;
    dx = (kx >= 3'd2) ? kx - 3'd2 : 3'd2 - kx;
    d  = (dy > dx) ? dy : dx;
    if (sel) begin
      return (ky == 3'd1 && kx == 3'd1) ? 6'sd27 : -6'sd1;
    end
    case (d)
      3'd0:    return 6'sd20;
      3'd1:    return 6'sd3;
      default: return 6'sd1;
    endcase
  endfunction

endpackage

[rtl/nkc_divider.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module nkc_divider #(
  parameter int N = 20,
  parameter int M = 11
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic [N-1:0] quotient,
  output logic [M-1:0] remainder,
  output logic         done
);

  localparam int CW = $clog2(N + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [M-1:0]  dvs;
  logic [M:0]    trial;

  assign trial = {remainder, quotient[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        remainder <= M'(trial - {1'b0, dvs});
        quotient  <= {quotient[N-2:0], 1'b1};
      end else begin
        remainder <= trial[M-1:0];
        quotient  <= {quotient[N-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/nkc_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration, counters, line store, tap accumulation,
// normalization through the divider and the output register. Uses nkc_pkg and nkc_divider.
module nkc_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [nkc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [nkc_pkg::CFG_W-1:0]     cfg_data,
  input  nkc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nkc_pkg::out_item_t            out_data,
  input  nkc_pkg::ctrl_cmd_t            cmd,
  output nkc_pkg::dp_stat_t             stat
);
  import nkc_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int RING  = 2 * MAX_RADIUS + 2;
  localparam int RGW   = $clog2(RING);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DVD   = (PW > ACCW) ? PW : ACCW;
  localparam int DVS   = (WW > NRMW) ? WW : NRMW;
  localparam int RSH   = 16;
  localparam int RCP   = (2 ** RSH + RING - 1) / RING;
  localparam logic [1:0] RMAX = (MAX_RADIUS >= 2) ? 2'd2 : 2'd1;

  logic [CFG_W-1:0] cfg_w, cfg_h;
  logic             cfg_sel;
  logic [SZW-1:0]   w_ext, h_ext, w_full, h_full;
  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [1:0]       r, kr;
  logic [2:0]       span;

  in_item_t       item;
  logic [XW-1:0]  col;
  logic [HW-1:0]  row;
  logic [RGW-1:0] iring;
  logic [PW-1:0]  pos;
  logic [XW-1:0]  ox;
  logic [HW-1:0]  oy;
  logic [RGW-1:0] oring;
  logic           resync;

  logic [HW+RSH-1:0] oy_prod;
  logic [HW-1:0]     oy_quo;

  logic [PW-1:0]  total, lyw, roww;
  logic [WW-1:0]  lx, lx_q;
  logic [HW-1:0]  ly;
  logic [WW:0]    oxr;
  logic [HW:0]    oyr;
  logic [PW:0]    need, got;
  logic           last;

  logic [23:0]    mem [DEPTH];
  logic           wr_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [23:0]    rd_data;
  logic [XW:0]    col_inc;

  logic [2:0]            ty, tx, ky, kx;
  logic [HW:0]           rys;
  logic [WW:0]           rxs;
  logic                  inb;
  logic [XW-1:0]         rx;
  logic [4:0]            rt, rr;
  logic signed [5:0]     wt_q;
  logic                  v_q;
  logic [5:0]            wabs;
  logic signed [ACCW-1:0] acc [3];
  logic signed [14:0]    prod [3];
  logic [NRMW-1:0]       norm;
  logic [7:0]            res [3];

  logic [DVD-1:0] dvd, quo;
  logic [DVS-1:0] dvs, rem;
  logic           div_done;

  assign w_ext  = {{(SZW - CFG_W){1'b0}}, cfg_w};
  assign h_ext  = {{(SZW - CFG_W){1'b0}}, cfg_h};
  assign w_full = (cfg_w == '0) ? SZW'(1) :
                  (w_ext > SZW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : w_ext;
  assign h_full = (cfg_h == '0) ? SZW'(1) :
                  (h_ext > SZW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT) : h_ext;
  assign w      = w_full[WW-1:0];
  assign h      = h_full[HW-1:0];
  assign r      = cfg_sel ? 2'd1 : RMAX;
  assign kr     = cfg_sel ? 2'd1 : 2'd2;
  assign span   = {r, 1'b0};

  assign col_inc = {1'b0, col} + 1'b1;
  assign wr_en   = cmd.write_step && !item.pad && (row < h);
  assign wr_addr = AW'(int'(iring) * MAX_WIDTH + int'(col));

  // The ring row of the output line comes from a reciprocal multiplication.
  assign oy_prod = (HW + RSH)'(oy) * (HW + RSH)'(RCP);

  assign oxr = (WW + 1)'(ox) + (WW + 1)'(r);
  assign oyr = (HW + 1)'(oy) + (HW + 1)'(r);
  assign lx  = (oxr > (WW + 1)'(w - 1'b1)) ? WW'(w - 1'b1) : oxr[WW-1:0];
  assign ly  = (oyr > (HW + 1)'(h - 1'b1)) ? HW'(h - 1'b1) : oyr[HW-1:0];
  assign need = (PW + 1)'(lyw) + (PW + 1)'(lx_q);
  assign got  = (row >= h) ? (PW + 1)'(total) : (PW + 1)'(roww) + (PW + 1)'(col);
  assign last = (pos == total - 1'b1);

  assign rys = (HW + 1)'(oy) + (HW + 1)'(ty);
  assign rxs = (WW + 1)'(ox) + (WW + 1)'(tx);
  assign inb = (rys >= (HW + 1)'(r)) && ((rys - (HW + 1)'(r)) < (HW + 1)'(h)) &&
               (rxs >= (WW + 1)'(r)) && ((rxs - (WW + 1)'(r)) < (WW + 1)'(w));
  assign rx  = XW'(rxs - (WW + 1)'(r));
  assign rt  = 5'(oring) + 5'(ty) + 5'(RING) - 5'(r);
  assign rr  = (rt >= 5'(2 * RING)) ? rt - 5'(2 * RING) :
               (rt >= 5'(RING)) ? rt - 5'(RING) : rt;
  assign rd_addr = AW'(int'(rr) * MAX_WIDTH + int'(rx));
  assign ky  = ty + 3'(kr) - 3'(r);
  assign kx  = tx + 3'(kr) - 3'(r);
  assign wabs = wt_q[5] ? 6'(-wt_q) : 6'(wt_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed({1'b0, rd_data[23 - 8 * c -: 8]}) * wt_q;
    end
  end

  always_comb begin
    dvd = '0;
    dvs = DVS'(1);
    case (cmd.div_src)
      DIV_POS: begin
        dvd = DVD'(pos);
        dvs = DVS'(w);
      end
      DIV_RED: begin
        dvd = acc[0][ACCW-1] ? '0 : DVD'(acc[0][ACCW-2:0]);
        dvs = DVS'(norm);
      end
      DIV_GREEN: begin
        dvd = acc[1][ACCW-1] ? '0 : DVD'(acc[1][ACCW-2:0]);
        dvs = DVS'(norm);
      end
      DIV_BLUE: begin
        dvd = acc[2][ACCW-1] ? '0 : DVD'(acc[2][ACCW-2:0]);
        dvs = DVS'(norm);
      end
      default: begin
        dvd = '0;
        dvs = DVS'(1);
      end
    endcase
  end

  nkc_divider #(
    .N(DVD),
    .M(DVS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .dividend(dvd),
    .divisor(dvs),
    .quotient(quo),
    .remainder(rem),
    .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {item.red_in, item.green_in, item.blue_in};
    end
    if (cmd.tap_step) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Configuration and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w   <= RESET_WIDTH;
      cfg_h   <= RESET_HEIGHT;
      cfg_sel <= 1'b0;
      col     <= '0;
      row     <= '0;
      iring   <= '0;
      pos     <= '0;
      ox      <= '0;
      oy      <= '0;
      oring   <= '0;
      resync  <= 1'b0;
    end else begin
      if (cmd.write_step && !item.pad && (row < h)) begin
        if (col_inc >= (XW + 1)'(w)) begin
          col   <= '0;
          row   <= row + 1'b1;
          iring <= (iring == RGW'(RING - 1)) ? '0 : iring + 1'b1;
        end else begin
          col <= col_inc[XW-1:0];
        end
      end
      if (cmd.div_latch && cmd.div_src == DIV_POS) begin
        ox <= XW'(rem);
        oy <= HW'(quo);
      end
      if (cmd.div_latch && cmd.div_src == DIV_RING) begin
        oring  <= RGW'(oy - HW'(oy_quo * HW'(RING)));
        resync <= 1'b0;
      end
      if (cmd.restart || (cmd.out_load && last)) begin
        col    <= '0;
        row    <= '0;
        iring  <= '0;
        pos    <= '0;
        ox     <= '0;
        oy     <= '0;
        oring  <= '0;
        resync <= 1'b0;
      end else if (cmd.out_load) begin
        pos <= pos + 1'b1;
        if ((WW)'(ox) == w - 1'b1) begin
          ox    <= '0;
          oy    <= oy + 1'b1;
          oring <= (oring == RGW'(RING - 1)) ? '0 : oring + 1'b1;
        end else begin
          ox <= ox + 1'b1;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            cfg_w  <= cfg_data;
            resync <= 1'b1;
          end
          REG_IMAGE_HEIGHT:  cfg_h   <= cfg_data;
          REG_KERNEL_SELECT: cfg_sel <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    oy_quo <= oy_prod[HW+RSH-1:RSH];
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.mul) begin
      total <= PW'(PW'(w) * PW'(h));
      lyw   <= PW'(PW'(ly) * PW'(w));
      roww  <= PW'(PW'(row) * PW'(w));
      lx_q  <= lx;
    end
    if (cmd.div_latch) begin
      case (cmd.div_src)
        DIV_RED:   res[0] <= (quo > DVD'(255)) ? 8'hFF : quo[7:0];
        DIV_GREEN: res[1] <= (quo > DVD'(255)) ? 8'hFF : quo[7:0];
        DIV_BLUE:  res[2] <= (quo > DVD'(255)) ? 8'hFF : quo[7:0];
        default: ;
      endcase
    end
  end

  // Tap sweep: the read for one tap is issued while the previous one accumulates.
  always_ff @(posedge clk) begin
    if (rst) begin
      ty  <= '0;
      tx  <= '0;
      v_q <= 1'b0;
    end else if (cmd.tap_init) begin
      ty  <= '0;
      tx  <= '0;
      v_q <= 1'b0;
    end else if (cmd.tap_step) begin
      v_q <= inb;
      if (tx == span) begin
        tx <= '0;
        ty <= ty + 1'b1;
      end else begin
        tx <= tx + 1'b1;
      end
    end else begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_step) begin
      wt_q <= tap_weight(cfg_sel, ky, kx);
    end
    if (cmd.tap_init) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= '0;
      end
      norm <= '0;
    end else if (v_q) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc[c] + {{(ACCW - 15){prod[c][14]}}, prod[c]};
      end
      norm <= norm + NRMW'(wabs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= '{red_out: res[0], green_out: res[1], blue_out: res[2],
                    frame_end: last};
    end
  end

  assign stat.resync    = resync;
  assign stat.div_done  = div_done;
  assign stat.past_end  = (pos >= total);
  assign stat.not_ready = (need >= got);
  assign stat.tap_last  = (ty == span) && (tx == span);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

[rtl/nkc_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine that sequences one beat through the datapath.
// Uses nkc_pkg.
module nkc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nkc_pkg::dp_stat_t  stat,
  output nkc_pkg::ctrl_cmd_t cmd
);
  import nkc_pkg::*;

  ctrl_state_t state, state_next;
  div_src_t    ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= DIV_RED;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write_step = 1'b1;
        state_next = stat.resync ? ST_RS_POS : ST_MUL;
      end
      ST_RS_POS: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_POS;
        state_next    = ST_RS_POS_W;
      end
      ST_RS_POS_W: begin
        cmd.div_src = DIV_POS;
        if (stat.div_done) begin
          cmd.div_latch = 1'b1;
          state_next    = ST_RS_RING;
        end
      end
      ST_RS_RING: begin
        cmd.div_src = DIV_RING;
        state_next  = ST_RS_RING_W;
      end
      ST_RS_RING_W: begin
        cmd.div_src   = DIV_RING;
        cmd.div_latch = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.past_end) begin
          cmd.restart = 1'b1;
          state_next  = ST_IDLE;
        end else if (stat.not_ready) begin
          state_next = ST_IDLE;
        end else begin
          cmd.tap_init = 1'b1;
          state_next   = ST_TAP;
        end
      end
      ST_TAP: begin
        cmd.tap_step = 1'b1;
        if (stat.tap_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ch_next    = DIV_RED;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = ch;
        state_next    = ST_DIV_W;
      end
      ST_DIV_W: begin
        cmd.div_src = ch;
        if (stat.div_done) begin
          cmd.div_latch = 1'b1;
          case (ch)
            DIV_RED: begin
              ch_next    = DIV_GREEN;
              state_next = ST_DIV;
            end
            DIV_GREEN: begin
              ch_next    = DIV_BLUE;
              state_next = ST_DIV;
            end
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/normalized_kernel_convolution_unit.sv]
`timescale 1ns / 1ps
// Top level of the normalized kernel convolution unit.
// Uses nkc_pkg, nkc_ctrl, nkc_datapath and the assertion macro header.
//
// The unit takes one beat at a time. A beat that yields no pixel passes through
// the idle, write, multiply and check states. A beat that yields a pixel also
// reads its T taps, one tap per cycle, from the line store, where T is the tap
// count of the kernel (25 for the 5x5 blur, 9 for the 3x3 sharpen), and then
// divides once for each of the three channels in a divider of D bits (21 at
// the default sizes), one quotient bit per cycle. The first beat after a write
// of image_width also runs one more division and a reciprocal multiplication
// to recover the output column and row. The output register lets the next beat
// enter while a finished pixel waits to be taken.
module normalized_kernel_convolution_unit #(
  parameter int MAX_WIDTH  = nkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nkc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = nkc_pkg::DEF_MAX_RADIUS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [nkc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [nkc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nkc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nkc_pkg::out_item_t            out_data
);
  import nkc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  nkc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat(stat),
    .cmd(cmd)
  );

  nkc_datapath #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cmd(cmd),
    .stat(stat)
  );

`include "normalized_kernel_convolution_unit_assert.svh"

  `NKC_ASSERT_NXT(a_leave_idle, clk, rst, in_valid && in_ready, !in_ready)
  `NKC_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, stat.out_free)
  `NKC_ASSERT_IMP(a_cmd_excl, clk, rst, 1'b1, $onehot0({cmd.write_step, cmd.tap_step, cmd.div_start, cmd.out_load}))

endmodule

[tb/normalized_kernel_convolution_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the normalized kernel convolution unit.
// Needs nkc_pkg and the unit; a built-in filter predictor checks every output beat.
module normalized_kernel_convolution_unit_tb;
  import nkc_pkg::*;

  typedef enum int {OP_CFG, OP_PIX, OP_PAD} op_t;

  typedef struct {
    op_t              op;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0] val;
    logic [7:0]       r, g, b;
    bit               has_exp;
    out_item_t        exp;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  normalized_kernel_convolution_unit u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filter predictor state.
  logic [23:0] pixel_ring [6][1024];
  int unsigned img_w, img_h, ksel;
  int unsigned in_col, in_row, out_pos;
  bit frame_done;

  out_item_t pixels_due[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int frames_seen = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  int quiet = 0;

  function automatic int kern_weight(int unsigned k, int dy, int dx);
    int ay, ax, d;
    ay = dy < 0 ? -dy : dy;
    ax = dx < 0 ? -dx : dx;
    d = ay > ax ? ay : ax;
    if (k != 0) return (d == 0) ? 27 : -1;
    if (d == 0) return 20;
    if (d == 1) return 3;
    return 1;
  endfunction

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  task automatic filter_step(input in_item_t it, output bit has, output out_item_t o);
    int unsigned w, h, total, r, ox, oy, lx, ly, need, got;
    int acc [3];
    int norm, wt, ry, rx;
    logic [23:0] px;
    w = (img_w == 0) ? 1 : (img_w > 1024 ? 1024 : img_w);
    h = (img_h == 0) ? 1 : (img_h > 1024 ? 1024 : img_h);
    total = w * h;
    r = (ksel != 0) ? 1 : 2;
    has = 0;
    o = '0;
    acc = '{0, 0, 0};
    norm = 0;
    if (!it.pad && in_row < h) begin
      pixel_ring[in_row % 6][in_col] = {it.red_in, it.green_in, it.blue_in};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (out_pos >= total) begin
      in_col = 0; in_row = 0; out_pos = 0;
      return;
    end
    ox = out_pos % w;
    oy = out_pos / w;
    lx = (ox + r > w - 1) ? w - 1 : ox + r;
    ly = (oy + r > h - 1) ? h - 1 : oy + r;
    need = ly * w + lx;
    got = (in_row >= h) ? total : in_row * w + in_col;
    if (need >= got) return;
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      ry = int'(oy) + dy;
      if (ry < 0 || ry >= int'(h)) continue;
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        rx = int'(ox) + dx;
        if (rx < 0 || rx >= int'(w)) continue;
        wt = kern_weight(ksel, dy, dx);
        px = pixel_ring[ry % 6][rx];
        acc[0] += int'(px[23:16]) * wt;
        acc[1] += int'(px[15:8]) * wt;
        acc[2] += int'(px[7:0]) * wt;
        norm += wt < 0 ? -wt : wt;
      end
    end
    has = 1;
    o.red_out = clamp8(acc[0] / norm);
    o.green_out = clamp8(acc[1] / norm);
    o.blue_out = clamp8(acc[2] / norm);
    if (out_pos == total - 1) begin
      o.frame_end = 1'b1;
      frame_done = 1;
      in_col = 0; in_row = 0; out_pos = 0;
    end else begin
      out_pos++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (pixels_due.size() == 0) begin
          $error("output beat with nothing expected: %h", out_data);
          errors++;
        end else begin
          out_item_t e;
          e = pixels_due.pop_front();
          if (out_data.red_out !== e.red_out) begin
            $error("red_out expected %0d actual %0d", e.red_out, out_data.red_out);
            errors++;
          end
          if (out_data.green_out !== e.green_out) begin
            $error("green_out expected %0d actual %0d", e.green_out, out_data.green_out);
            errors++;
          end
          if (out_data.blue_out !== e.blue_out) begin
            $error("blue_out expected %0d actual %0d", e.blue_out, out_data.blue_out);
            errors++;
          end
          if (out_data.frame_end !== e.frame_end) begin
            $error("frame_end expected %0d actual %0d", e.frame_end, out_data.frame_end);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= 6000) begin
        $display("watchdog expired with %0d beats outstanding", pixels_due.size());
        $display("normalized_kernel_convolution_unit_tb failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: img_w = val;
      REG_IMAGE_HEIGHT: img_h = val;
      default: ksel = val[0];
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_beat(input in_item_t it, input bit has_exp, input out_item_t exp);
    bit has;
    out_item_t o;
    if ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_pct);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    filter_step(it, has, o);
    if (has) pixels_due.push_back(has_exp ? exp : o);
    if (has_exp && !has) begin
      $error("directed row expects a pixel the predictor does not produce");
      errors++;
    end
  endtask

  function automatic logic [7:0] chan_val();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t rand_pixel(bit pad);
    in_item_t it;
    it.red_in = chan_val();
    it.green_in = chan_val();
    it.blue_in = chan_val();
    it.pad = pad;
    return it;
  endfunction

  task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned k);
    int unsigned n;
    settle();
    write_reg(REG_IMAGE_WIDTH, w[CFG_W-1:0]);
    write_reg(REG_IMAGE_HEIGHT, h[CFG_W-1:0]);
    write_reg(REG_KERNEL_SELECT, k[CFG_W-1:0]);
    n = ((w == 0) ? 1 : (w > 1024 ? 1024 : w)) * ((h == 0) ? 1 : (h > 1024 ? 1024 : h));
    frame_done = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_beat(rand_pixel(1'b1), 0, '0);
      send_beat(rand_pixel(1'b0), 0, '0);
    end
    while (!frame_done) send_beat(rand_pixel($urandom_range(9) < 7), 0, '0);
    frames_seen++;
  endtask

  function automatic script_row_t row(op_t op, logic [REG_IDX_W-1:0] idx,
                                     logic [CFG_W-1:0] val, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, bit has_exp, out_item_t exp);
    script_row_t s;
    s.op = op; s.idx = idx; s.val = val; s.r = r; s.g = g; s.b = b;
    s.has_exp = has_exp; s.exp = exp;
    return s;
  endfunction

  script_row_t script[$];

  initial begin
    in_item_t it;
    int unsigned mode;
    int unsigned budget;
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 1024; j++) pixel_ring[i][j] = '0;
    img_w = RESET_WIDTH;
    img_h = RESET_HEIGHT;
    ksel = 0;
    in_col = 0; in_row = 0; out_pos = 0;

    // Zero sizes act as one: a lone pixel filters to itself.
    script.push_back(row(OP_CFG, REG_IMAGE_WIDTH, 11'd0, 0, 0, 0, 0, '0));
    script.push_back(row(OP_CFG, REG_IMAGE_HEIGHT, 11'd0, 0, 0, 0, 0, '0));
    script.push_back(row(OP_PIX, '0, '0, 8'd255, 8'd0, 8'd128, 1, '{8'd255, 8'd0, 8'd128, 1'b1}));
    script.push_back(row(OP_PAD, '0, '0, 8'd17, 8'd34, 8'd51, 0, '0));
    script.push_back(row(OP_CFG, REG_KERNEL_SELECT, 11'd1, 0, 0, 0, 0, '0));
    script.push_back(row(OP_PIX, '0, '0, 8'd0, 8'd255, 8'd1, 1, '{8'd0, 8'd255, 8'd1, 1'b1}));
    // Two-pixel blur row; the extra pixel after the frame only flushes.
    script.push_back(row(OP_CFG, REG_KERNEL_SELECT, 11'd0, 0, 0, 0, 0, '0));
    script.push_back(row(OP_CFG, REG_IMAGE_WIDTH, 11'd2, 0, 0, 0, 0, '0));
    script.push_back(row(OP_PIX, '0, '0, 8'd255, 8'd255, 8'd255, 0, '0));
    script.push_back(row(OP_PIX, '0, '0, 8'd0, 8'd0, 8'd0, 0, '0));
    script.push_back(row(OP_PIX, '0, '0, 8'd99, 8'd99, 8'd99, 0, '0));
    // Sharpen 4x4, then the frame shrinks under the output position.
    script.push_back(row(OP_CFG, REG_KERNEL_SELECT, 11'd1, 0, 0, 0, 0, '0));
    script.push_back(row(OP_CFG, REG_IMAGE_WIDTH, 11'd4, 0, 0, 0, 0, '0));
    script.push_back(row(OP_CFG, REG_IMAGE_HEIGHT, 11'd4, 0, 0, 0, 0, '0));
    for (int i = 0; i < 8; i++)
      script.push_back(row(OP_PIX, '0, '0, (i % 2) ? 8'd255 : 8'd0, 8'(i * 37),
                           (i % 3) ? 8'd0 : 8'd255, 0, '0));
    script.push_back(row(OP_CFG, REG_IMAGE_WIDTH, 11'd1, 0, 0, 0, 0, '0));
    script.push_back(row(OP_CFG, REG_IMAGE_HEIGHT, 11'd1, 0, 0, 0, 0, '0));
    script.push_back(row(OP_PIX, '0, '0, 8'd200, 8'd100, 8'd50, 0, '0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == OP_CFG) begin
        settle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        it.red_in = script[i].r;
        it.green_in = script[i].g;
        it.blue_in = script[i].b;
        it.pad = (script[i].op == OP_PAD);
        send_beat(it, script[i].has_exp, script[i].exp);
      end
    end

    // An oversized width saturates to the maximum line length.
    snd_pct = 0; rcv_pct = 0;
    run_frame(2047, 1, 0);

    budget = beats_in + 250;
    mode = 0;
    while (beats_in < budget) begin
      case (mode % 5)
        0: begin snd_pct = 0; rcv_pct = 0; end
        1: begin snd_pct = 83; rcv_pct = 0; end
        2: begin snd_pct = 0; rcv_pct = 83; end
        3: begin snd_pct = 19; rcv_pct = 19; end
        default: begin snd_pct = 0; rcv_pct = 0; end
      endcase
      run_frame($urandom_range(12), $urandom_range(8), $urandom_range(1));
      mode++;
    end

    settle();
    $display("Covered %0d input beats and %0d output beats over %0d frames,",
             beats_in, beats_out, frames_seen);
    $display("with both kernels, saturated and degenerate sizes and a mid-frame resize.");
    if (errors == 0) begin
      $display("normalized_kernel_convolution_unit_tb passed");
    end else begin
      $display("normalized_kernel_convolution_unit_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/nkc_pkg.sv
rtl/nkc_divider.sv
rtl/nkc_datapath.sv
rtl/nkc_ctrl.sv
rtl/normalized_kernel_convolution_unit.sv
tb/normalized_kernel_convolution_unit_tb.sv
